// ===== rtl/obm_pkg.sv =====
// shared types and constants for the one-wire bus master
`timescale 1ns / 1ps

package obm_pkg;

    localparam int TimerWidth = 10;

    // command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_WRITE_LOW       = 3'd0;
    localparam logic [2:0] CFG_WRITE_SLOT      = 3'd1;
    localparam logic [2:0] CFG_READ_LOW        = 3'd2;
    localparam logic [2:0] CFG_READ_SAMPLE     = 3'd3;
    localparam logic [2:0] CFG_READ_SLOT       = 3'd4;
    localparam logic [2:0] CFG_RESET_LOW       = 3'd5;
    localparam logic [2:0] CFG_PRESENCE_SAMPLE = 3'd6;
    localparam logic [2:0] CFG_RESET_TAIL      = 3'd7;

    // reset values of the timing registers
    localparam logic [7:0] WRITE_LOW_RST       = 8'd5;
    localparam logic [7:0] WRITE_SLOT_RST      = 8'd85;
    localparam logic [7:0] READ_LOW_RST        = 8'd3;
    localparam logic [7:0] READ_SAMPLE_RST     = 8'd13;
    localparam logic [7:0] READ_SLOT_RST       = 8'd66;
    localparam logic [9:0] RESET_LOW_RST       = 10'd500;
    localparam logic [9:0] PRESENCE_SAMPLE_RST = 10'd30;
    localparam logic [9:0] RESET_TAIL_RST      = 10'd500;

    // released gap after a written byte
    localparam logic [TimerWidth-1:0] GAP_US = 10'd100;

    typedef struct packed {
        logic [7:0] write_low_us;
        logic [7:0] write_slot_us;
        logic [7:0] read_low_us;
        logic [7:0] read_sample_us;
        logic [7:0] read_slot_us;
        logic [9:0] reset_low_us;
        logic [9:0] presence_sample_us;
        logic [9:0] reset_tail_us;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       presence;
    } res_t;

    // last tick of a phase of length len (a length of zero acts as one)
    function automatic logic at_end(input logic [TimerWidth-1:0] t,
                                    input logic [TimerWidth-1:0] len);
        return ({1'b0, t} + {{TimerWidth{1'b0}}, 1'b1}) >= {1'b0, len};
    endfunction

endpackage

// ===== rtl/obm_cfg_regs.sv =====
// timing configuration registers of the one-wire bus master
`timescale 1ns / 1ps

module obm_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [9:0]        cfg_data,
    output obm_pkg::cfg_t     cfg
);

    obm_pkg::cfg_t cfg_reg;
    obm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                obm_pkg::CFG_WRITE_LOW:       cfg_next.write_low_us       = cfg_data[7:0];
                obm_pkg::CFG_WRITE_SLOT:      cfg_next.write_slot_us      = cfg_data[7:0];
                obm_pkg::CFG_READ_LOW:        cfg_next.read_low_us        = cfg_data[7:0];
                obm_pkg::CFG_READ_SAMPLE:     cfg_next.read_sample_us     = cfg_data[7:0];
                obm_pkg::CFG_READ_SLOT:       cfg_next.read_slot_us       = cfg_data[7:0];
                obm_pkg::CFG_RESET_LOW:       cfg_next.reset_low_us       = cfg_data;
                obm_pkg::CFG_PRESENCE_SAMPLE: cfg_next.presence_sample_us = cfg_data;
                obm_pkg::CFG_RESET_TAIL:      cfg_next.reset_tail_us      = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.write_low_us       <= obm_pkg::WRITE_LOW_RST;
            cfg_reg.write_slot_us      <= obm_pkg::WRITE_SLOT_RST;
            cfg_reg.read_low_us        <= obm_pkg::READ_LOW_RST;
            cfg_reg.read_sample_us     <= obm_pkg::READ_SAMPLE_RST;
            cfg_reg.read_slot_us       <= obm_pkg::READ_SLOT_RST;
            cfg_reg.reset_low_us       <= obm_pkg::RESET_LOW_RST;
            cfg_reg.presence_sample_us <= obm_pkg::PRESENCE_SAMPLE_RST;
            cfg_reg.reset_tail_us      <= obm_pkg::RESET_TAIL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/obm_core.sv =====
// bus sequencer: phase, slot timer, bit shifter and result flags
`timescale 1ns / 1ps

module obm_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [1:0]        command,
    input  logic [7:0]        tx_byte,
    input  logic              bus_level,
    input  obm_pkg::cfg_t     cfg,
    output obm_pkg::res_t     res
);

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_RST_LOW  = 6'b000010,
        PH_RST_WAIT = 6'b000100,
        PH_WR_SLOT  = 6'b001000,
        PH_WR_GAP   = 6'b010000,
        PH_RD_SLOT  = 6'b100000
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic [obm_pkg::TimerWidth-1:0]     timer_reg, timer_next;
    logic [2:0]                         bit_cnt_reg, bit_cnt_next;
    logic [7:0]                         shift_reg, shift_next;
    logic [7:0]                         rx_reg, rx_next;
    logic                               seen_reg, seen_next;
    logic                               pres_reg, pres_next;

    // working copies after a command start
    phase_t                             ph;
    logic [obm_pkg::TimerWidth-1:0]     t;
    logic [2:0]                         bc;
    logic [7:0]                         sh;
    logic                               ps;
    logic                               last;
    logic                               drive;
    logic                               done;

    always_comb
    begin
        ph    = phase_reg;
        t     = timer_reg;
        bc    = bit_cnt_reg;
        sh    = shift_reg;
        ps    = seen_reg;
        last  = 1'b0;
        drive = 1'b0;
        done  = 1'b0;

        if (phase_reg == PH_IDLE && command != obm_pkg::CMD_NONE)
        begin
            t  = '0;
            bc = '0;
            sh = (command == obm_pkg::CMD_WRITE) ? tx_byte : 8'd0;
            unique case (command)
                obm_pkg::CMD_RESET: begin ph = PH_RST_LOW; ps = 1'b0; end
                obm_pkg::CMD_WRITE: ph = PH_WR_SLOT;
                default:            ph = PH_RD_SLOT;
            endcase
        end

        phase_next   = ph;
        timer_next   = t;
        bit_cnt_next = bc;
        shift_next   = sh;
        seen_next    = ps;
        rx_next      = rx_reg;
        pres_next    = pres_reg;

        unique case (ph)
            PH_IDLE:
            begin
                timer_next = t;
            end
            PH_RST_LOW:
            begin
                drive = 1'b1;
                if (obm_pkg::at_end(t, cfg.reset_low_us))
                begin
                    phase_next = PH_RST_WAIT;
                    timer_next = '0;
                end
                else
                    timer_next = t + 1'b1;
            end
            PH_RST_WAIT:
            begin
                if (t == cfg.presence_sample_us && !bus_level)
                    seen_next = 1'b1;
                if (obm_pkg::at_end(t, cfg.reset_tail_us))
                begin
                    pres_next  = seen_next & bus_level;
                    phase_next = PH_IDLE;
                    timer_next = '0;
                    done       = 1'b1;
                end
                else
                    timer_next = t + 1'b1;
            end
            PH_WR_SLOT:
            begin
                last  = obm_pkg::at_end(t, {2'b00, cfg.write_slot_us});
                drive = !last && (t < {2'b00, cfg.write_low_us} || !sh[0]);
                if (last)
                begin
                    shift_next = {1'b0, sh[7:1]};
                    timer_next = '0;
                    if (bc == 3'd7)
                    begin
                        phase_next   = PH_WR_GAP;
                        bit_cnt_next = '0;
                    end
                    else
                        bit_cnt_next = bc + 1'b1;
                end
                else
                    timer_next = t + 1'b1;
            end
            PH_WR_GAP:
            begin
                if (obm_pkg::at_end(t, obm_pkg::GAP_US))
                begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                    done       = 1'b1;
                end
                else
                    timer_next = t + 1'b1;
            end
            PH_RD_SLOT:
            begin
                last  = obm_pkg::at_end(t, {2'b00, cfg.read_slot_us});
                drive = !last && (t < {2'b00, cfg.read_low_us});
                if (t == {2'b00, cfg.read_sample_us} && bus_level)
                    shift_next = sh | (8'd1 << bc);
                if (last)
                begin
                    timer_next = '0;
                    if (bc == 3'd7)
                    begin
                        rx_next      = shift_next;
                        phase_next   = PH_IDLE;
                        bit_cnt_next = '0;
                        done         = 1'b1;
                    end
                    else
                        bit_cnt_next = bc + 1'b1;
                end
                else
                    timer_next = t + 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
                timer_next = '0;
            end
        endcase

        res.drive_low = drive;
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = done;
        res.rx_byte   = rx_next;
        res.presence  = pres_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
            rx_reg      <= '0;
            seen_reg    <= 1'b0;
            pres_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            rx_reg      <= rx_next;
            seen_reg    <= seen_next;
            pres_reg    <= pres_next;
        end
    end

endmodule

// ===== rtl/onewire_bus_master_top.sv =====
// top level of the one-wire bus master: word registers and handshake
`timescale 1ns / 1ps

// one-wire bus master, stepped by one input word per microsecond tick
// - input channel: in_valid / in_stall with command, tx_byte and the sampled
//   bus_level; every accepted word is one tick of bus time
// - output channel: out_valid / out_stall with drive_low, busy_res, done_res,
//   rx_byte and presence; exactly one output word per input word, in order
// - a command (reset, write byte, read byte) is taken only while idle,
//   otherwise it is ignored; the tick carrying it is the first tick of the
//   operation
// - timing registers are written through cfg_we / cfg_index / cfg_data;
//   the user must write them only while the block is idle; the block does not enforce it
// - an accepted word goes into the input register, then the sequencer step
//   writes its result into the output register
// - throughput: one word per cycle while the receiver does not stall; the
//   step through the sequencer state is combinational and sets that figure
// - when the receiver stalls, the output word holds and the input register
//   keeps its word; in_stall rises only once the input register is full too
// - reset: timing registers take their default values, the sequencer goes
//   idle and both word registers empty

module onewire_bus_master_top
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration port
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_data,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] tx_byte,
    input  logic       bus_level,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       drive_low,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       presence
);

    obm_pkg::cfg_t cfg;
    obm_pkg::res_t res;

    // input word register
    logic          in_valid_reg, in_valid_next;
    logic [1:0]    cmd_reg;
    logic [7:0]    tx_reg;
    logic          lvl_reg;

    // output word register
    logic          out_valid_reg, out_valid_next;
    obm_pkg::res_t res_reg;

    logic          out_free;
    logic          in_fire;
    logic          step_en;

    // output register can take a word when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    assign step_en  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (step_en)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step_en)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= command;
            tx_reg  <= tx_byte;
            lvl_reg <= bus_level;
        end
        if (step_en)
            res_reg <= res;
    end

    obm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer advances one tick per word moved into the output register
    obm_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .command   (cmd_reg),
        .tx_byte   (tx_reg),
        .bus_level (lvl_reg),
        .cfg       (cfg),
        .res       (res)
    );

    assign out_valid = out_valid_reg;
    assign drive_low = res_reg.drive_low;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;
    assign rx_byte   = res_reg.rx_byte;
    assign presence  = res_reg.presence;

endmodule

// ===== test/onewire_bus_master_top_tb.sv =====
// testbench for the one-wire bus master top level: tick-by-tick prediction and word checks
`timescale 1ns / 1ps

// every input word is one microsecond of bus time and brings back exactly one
// output word, so the testbench keeps its own copy of the sequencer, steps it
// on each accepted input word and queues the word that must come back
// - directed tests: low times and sample points at their reset values with
//   short slots, shortest timing, then the awkward timing corners (presence
//   sample past the tail or on its last tick, read sample at the slot end or
//   inside the low time, write low time covering the whole slot)
// - random traffic: a handful of reset / write / read operations with random
//   content and short random timing, some with random bus levels, commands
//   thrown in while busy
// - slot lengths stay short so that the whole run is a few hundred words
// - timing registers are only written once the sequencer is idle and every
//   queued word has come back

module onewire_bus_master_top_tb;

    // cycles without any accepted word before the run is given up
    localparam int QuietLimit = 5000;

    // sequencer phases as this testbench tracks them
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_RST_LOW  = 6'b000010,
        ST_RST_WAIT = 6'b000100,
        ST_WR_SLOT  = 6'b001000,
        ST_WR_GAP   = 6'b010000,
        ST_RD_SLOT  = 6'b100000
    } seq_state_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [9:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic       bus_level;
    logic       out_valid;
    logic       out_stall;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       presence;

    // own copy of the timing registers and the sequencer state
    obm_pkg::cfg_t bus_cfg;
    seq_state_t    seq_state;
    int unsigned   tick_timer;
    logic [2:0]    bit_idx;
    logic [7:0]    shifter;
    logic [7:0]    rx_last;
    logic          seen_low;
    logic          presence_last;

    // output words still to come back, oldest first
    obm_pkg::res_t bus_words_q[$];

    int error_count;
    int quiet_cycles;
    bit calm;

    onewire_bus_master_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .tx_byte   (tx_byte),
        .bus_level (bus_level),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive_low (drive_low),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .rx_byte   (rx_byte),
        .presence  (presence)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // sequencer prediction
    // ------------------------------------------------------------------

    function automatic obm_pkg::cfg_t timing(input int wl, input int ws, input int rl,
                                             input int rs, input int rsl, input int rlo,
                                             input int ps, input int rt);
        obm_pkg::cfg_t c;
        c.write_low_us       = 8'(wl);
        c.write_slot_us      = 8'(ws);
        c.read_low_us        = 8'(rl);
        c.read_sample_us     = 8'(rs);
        c.read_slot_us       = 8'(rsl);
        c.reset_low_us       = 10'(rlo);
        c.presence_sample_us = 10'(ps);
        c.reset_tail_us      = 10'(rt);
        return c;
    endfunction

    function automatic obm_pkg::cfg_t default_timing();
        return timing(obm_pkg::WRITE_LOW_RST, obm_pkg::WRITE_SLOT_RST,
                      obm_pkg::READ_LOW_RST, obm_pkg::READ_SAMPLE_RST,
                      obm_pkg::READ_SLOT_RST, obm_pkg::RESET_LOW_RST,
                      obm_pkg::PRESENCE_SAMPLE_RST, obm_pkg::RESET_TAIL_RST);
    endfunction

    function automatic void clear_master();
        bus_cfg       = default_timing();
        seq_state     = ST_IDLE;
        tick_timer    = 0;
        bit_idx       = '0;
        shifter       = '0;
        rx_last       = '0;
        seen_low      = 1'b0;
        presence_last = 1'b0;
    endfunction

    // last tick of a stretch of len ticks; a length of zero behaves as one
    function automatic bit slot_over(input int unsigned t, input int unsigned len);
        return t + 1 >= len;
    endfunction

    // one microsecond tick of the bus master
    function automatic obm_pkg::res_t master_tick(input logic [1:0] cmd,
                                                  input logic [7:0] tx,
                                                  input logic lvl);
        obm_pkg::res_t r;
        logic          drv;
        logic          fin;
        bit            last;
        logic          b;
        int unsigned   t;
        drv = 1'b0;
        fin = 1'b0;
        // a command is only taken while idle
        if (seq_state == ST_IDLE && cmd != obm_pkg::CMD_NONE)
        begin
            case (cmd)
                obm_pkg::CMD_RESET: seq_state = ST_RST_LOW;
                obm_pkg::CMD_WRITE: seq_state = ST_WR_SLOT;
                default:            seq_state = ST_RD_SLOT;
            endcase
            tick_timer = 0;
            bit_idx    = '0;
            shifter    = (cmd == obm_pkg::CMD_WRITE) ? tx : 8'h00;
            if (cmd == obm_pkg::CMD_RESET)
                seen_low = 1'b0;
        end
        t = tick_timer;
        case (seq_state)
            ST_RST_LOW:
            begin
                drv = 1'b1;
                if (slot_over(t, bus_cfg.reset_low_us))
                begin
                    seq_state  = ST_RST_WAIT;
                    tick_timer = 0;
                end
                else
                    tick_timer = t + 1;
            end
            ST_RST_WAIT:
            begin
                if (t == bus_cfg.presence_sample_us && !lvl)
                    seen_low = 1'b1;
                // presence needs the pulse and the bus back high at the end
                if (slot_over(t, bus_cfg.reset_tail_us))
                begin
                    presence_last = seen_low & lvl;
                    seq_state     = ST_IDLE;
                    tick_timer    = 0;
                    fin           = 1'b1;
                end
                else
                    tick_timer = t + 1;
            end
            ST_WR_SLOT:
            begin
                b    = shifter[0];
                last = slot_over(t, bus_cfg.write_slot_us);
                drv  = !last && (t < bus_cfg.write_low_us || !b);
                if (last)
                begin
                    shifter    = shifter >> 1;
                    tick_timer = 0;
                    if (bit_idx == 3'd7)
                    begin
                        seq_state = ST_WR_GAP;
                        bit_idx   = '0;
                    end
                    else
                        bit_idx = bit_idx + 3'd1;
                end
                else
                    tick_timer = t + 1;
            end
            ST_WR_GAP:
            begin
                if (slot_over(t, obm_pkg::GAP_US))
                begin
                    seq_state  = ST_IDLE;
                    tick_timer = 0;
                    fin        = 1'b1;
                end
                else
                    tick_timer = t + 1;
            end
            ST_RD_SLOT:
            begin
                last = slot_over(t, bus_cfg.read_slot_us);
                drv  = !last && t < bus_cfg.read_low_us;
                if (t == bus_cfg.read_sample_us && lvl)
                    shifter[bit_idx] = 1'b1;
                if (last)
                begin
                    tick_timer = 0;
                    if (bit_idx == 3'd7)
                    begin
                        rx_last   = shifter;
                        seq_state = ST_IDLE;
                        bit_idx   = '0;
                        fin       = 1'b1;
                    end
                    else
                        bit_idx = bit_idx + 3'd1;
                end
                else
                    tick_timer = t + 1;
            end
            default:
            begin
                seq_state  = ST_IDLE;
                tick_timer = 0;
            end
        endcase
        r.drive_low = drv;
        r.busy_res  = (seq_state != ST_IDLE);
        r.done_res  = fin;
        r.rx_byte   = rx_last;
        r.presence  = presence_last;
        return r;
    endfunction

    // bus level a well-behaved device would give; data[0] says whether a
    // device answers a reset, data holds the byte it returns on a read
    function automatic logic line_level(input bit tidy, input logic [7:0] data);
        if (!tidy)
            return 1'($urandom);
        case (seq_state)
            ST_RST_WAIT: return !(data[0] && tick_timer == bus_cfg.presence_sample_us);
            ST_RD_SLOT:  return data[bit_idx];
            ST_IDLE:     return data[0];
            default:     return 1'b1;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // random stalls on the output side, none during a calm stretch
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 21);

    // one tick word; valid stays high on return so back-to-back words need
    // no second assignment in the same step
    task automatic send_tick(input logic [1:0] cmd, input logic [7:0] tx, input logic lvl);
        if (!calm)
        begin
            while ($urandom_range(99) < 21)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        tx_byte   <= tx;
        bus_level <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bus_words_q.push_back(master_tick(cmd, tx, lvl));
    endtask

    // a few idle ticks, then one command run until the sequencer is idle
    // again, with stray commands now and then while it is busy
    task automatic run_op(input logic [1:0] op, input logic [7:0] data, input bit tidy);
        logic [1:0] stray;
        int         gaps;
        gaps = $urandom_range(3);
        repeat (gaps)
            send_tick(obm_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
        send_tick(op, data, line_level(tidy, data));
        while (seq_state != ST_IDLE)
        begin
            stray = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : obm_pkg::CMD_NONE;
            send_tick(stray, 8'($urandom), line_level(tidy, data));
        end
    endtask

    // finish any operation, then hold off until every word is back
    task automatic settle();
        while (seq_state != ST_IDLE)
            send_tick(obm_pkg::CMD_NONE, 8'($urandom), 1'b1);
        in_valid <= 1'b0;
        @(posedge clk);
        while (bus_words_q.size() != 0)
            @(posedge clk);
        // input and output word registers plus margin
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            obm_pkg::CFG_WRITE_LOW:       bus_cfg.write_low_us       = val[7:0];
            obm_pkg::CFG_WRITE_SLOT:      bus_cfg.write_slot_us      = val[7:0];
            obm_pkg::CFG_READ_LOW:        bus_cfg.read_low_us        = val[7:0];
            obm_pkg::CFG_READ_SAMPLE:     bus_cfg.read_sample_us     = val[7:0];
            obm_pkg::CFG_READ_SLOT:       bus_cfg.read_slot_us       = val[7:0];
            obm_pkg::CFG_RESET_LOW:       bus_cfg.reset_low_us       = val;
            obm_pkg::CFG_PRESENCE_SAMPLE: bus_cfg.presence_sample_us = val;
            default:                      bus_cfg.reset_tail_us      = val;
        endcase
    endtask

    task automatic load_timing(input obm_pkg::cfg_t c);
        settle();
        write_reg(obm_pkg::CFG_WRITE_LOW,       {2'b00, c.write_low_us});
        write_reg(obm_pkg::CFG_WRITE_SLOT,      {2'b00, c.write_slot_us});
        write_reg(obm_pkg::CFG_READ_LOW,        {2'b00, c.read_low_us});
        write_reg(obm_pkg::CFG_READ_SAMPLE,     {2'b00, c.read_sample_us});
        write_reg(obm_pkg::CFG_READ_SLOT,       {2'b00, c.read_slot_us});
        write_reg(obm_pkg::CFG_RESET_LOW,       c.reset_low_us);
        write_reg(obm_pkg::CFG_PRESENCE_SAMPLE, c.presence_sample_us);
        write_reg(obm_pkg::CFG_RESET_TAIL,      c.reset_tail_us);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly short values, now and then an extreme
    function automatic int span(input int lo, input int hi_short, input int hi_max);
        int r;
        r = $urandom_range(39);
        if (r < 4)
            return lo;
        if (r == 4)
            return hi_max;
        return $urandom_range(hi_short, lo);
    endfunction

    // slot and phase lengths stay short; low times and sample points may
    // land anywhere, past the end included
    function automatic obm_pkg::cfg_t pick_timing();
        return timing(span(1, 4, 255), $urandom_range(5, 2), span(1, 4, 255),
                      span(2, 6, 255), $urandom_range(6, 3), $urandom_range(6, 1),
                      span(1, 8, 1023), $urandom_range(10, 2));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // low times and sample points at their reset values, slots cut short;
    // run without any idling on either side
    task automatic test_default_timing();
        settle();
        write_reg(obm_pkg::CFG_WRITE_SLOT, 10'd7);
        write_reg(obm_pkg::CFG_READ_SLOT,  10'd15);
        write_reg(obm_pkg::CFG_RESET_LOW,  10'd4);
        write_reg(obm_pkg::CFG_RESET_TAIL, 10'd32);
        cfg_we <= 1'b0;
        @(posedge clk);
        calm = 1'b1;
        run_op(obm_pkg::CMD_RESET, 8'h01, 1'b1);
        run_op(obm_pkg::CMD_WRITE, 8'hA5, 1'b1);
        run_op(obm_pkg::CMD_READ,  8'h3C, 1'b1);
        calm = 1'b0;
    endtask

    task automatic test_shortest_timing();
        load_timing(timing(1, 2, 1, 2, 3, 1, 1, 2));
        run_op(obm_pkg::CMD_READ,  8'hC3, 1'b1);
        run_op(obm_pkg::CMD_RESET, 8'h01, 1'b1);
        run_op(obm_pkg::CMD_RESET, 8'h00, 1'b0);
    endtask

    task automatic test_timing_corners();
        // presence sample far after the tail: never taken
        load_timing(timing(5, 20, 3, 8, 20, 2, 1023, 4));
        run_op(obm_pkg::CMD_RESET, 8'h01, 1'b1);
        // presence sample on the last released tick
        load_timing(timing(5, 20, 3, 8, 20, 2, 3, 4));
        run_op(obm_pkg::CMD_RESET, 8'h01, 1'b1);
        // read sample at the slot end: every bit reads 0
        load_timing(timing(5, 20, 3, 3, 3, 2, 1, 4));
        run_op(obm_pkg::CMD_READ, 8'hFF, 1'b1);
        // read sample while the master still holds the bus low
        load_timing(timing(5, 20, 255, 1, 3, 2, 1, 4));
        run_op(obm_pkg::CMD_READ, 8'hA5, 1'b1);
        // write low time well past the slot: a 1 looks like a 0
        load_timing(timing(255, 2, 3, 8, 20, 2, 1, 4));
        run_op(obm_pkg::CMD_WRITE, 8'h0F, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [1:0] op;
        int         r;
        for (int n = 0; n < 5; n++)
        begin
            if (n % 2 == 0)
                load_timing(pick_timing());
            // writes are long because of the gap, so keep them rare
            r = $urandom_range(7);
            if (r == 0)
                op = obm_pkg::CMD_WRITE;
            else if (r < 5)
                op = obm_pkg::CMD_READ;
            else
                op = obm_pkg::CMD_RESET;
            run_op(op, 8'($urandom), $urandom_range(3) != 0);
        end
    endtask

    // ------------------------------------------------------------------
    // output word check
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_words
        obm_pkg::res_t got;
        obm_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {drive_low, busy_res, done_res, rx_byte, presence};
            if (bus_words_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("word with nothing outstanding: drive %0b busy %0b done %0b",
                             got.drive_low, got.busy_res, got.done_res,
                             " rx %02h pres %0b", got.rx_byte, got.presence);
            end
            else
            begin
                want = bus_words_q.pop_front();
                if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
                    got.done_res !== want.done_res || got.rx_byte !== want.rx_byte ||
                    got.presence !== want.presence)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("word differs at %0t: want drive %0b busy %0b done %0b",
                                 $realtime, want.drive_low, want.busy_res,
                                 want.done_res, " rx %02h pres %0b",
                                 want.rx_byte, want.presence);
                        $display("  got drive %0b busy %0b done %0b rx %02h pres %0b",
                                 got.drive_low, got.busy_res, got.done_res,
                                 got.rx_byte, got.presence);
                    end
                end
            end
        end
    end

    // watchdog: give up when no word moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("onewire_bus_master_top: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        error_count  = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        rst_n        = 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= obm_pkg::CFG_WRITE_LOW;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        command      <= obm_pkg::CMD_NONE;
        tx_byte      <= '0;
        bus_level    <= 1'b1;
        out_stall    <= 1'b0;
        clear_master();
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_timing();
        test_shortest_timing();
        test_timing_corners();
        test_random_traffic();

        // drain the pipe and allow for late stray words
        in_valid <= 1'b0;
        @(posedge clk);
        while (bus_words_q.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (error_count == 0 && bus_words_q.size() == 0)
            $display("onewire_bus_master_top: match");
        else
            $display("onewire_bus_master_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/obm_pkg.sv
rtl/obm_cfg_regs.sv
rtl/obm_core.sv
rtl/onewire_bus_master_top.sv
test/onewire_bus_master_top_tb.sv
